### src/download_body_verifier_defines.svh
// Assertion macros for the download body verifier checker.
// Each macro expects a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef DOWNLOAD_BODY_VERIFIER_DEFINES_SVH
`define DOWNLOAD_BODY_VERIFIER_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define DBV_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("download body verifier: same-cycle check failed");

// Consequent in the cycle after the antecedent.
`define DBV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("download body verifier: next-cycle check failed");

`endif

### src/dbv_pkg.sv
// Shared types, constants and the FNV-1a step for the download body verifier.
// No dependencies; every module of the block imports this package.
package dbv_pkg;

  localparam int BUFFER_BYTES = 4096;
  localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
  localparam int LEN_W        = 13;
  localparam int HASH_W       = 32;
  localparam int CFG_W        = 32;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [7:0]        CHAR_CR   = 8'h0D;
  localparam logic [7:0]        CHAR_LF   = 8'h0A;

  localparam logic CFG_EXP_SIZE = 1'b0;
  localparam logic CFG_EXP_SUM  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_BIG  = 2'd1,
    ST_SIZE     = 2'd2,
    ST_CHECKSUM = 2'd3
  } status_e;

  // Length and hash of one finished response.
  typedef struct packed {
    logic [CNT_W-1:0]  len;
    logic [HASH_W-1:0] hash;
  } fin_t;

  // One FNV-1a step. The prime 16777619 is 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1,
  // so the multiply is a sum of six shifted copies.
  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [7:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {24'd0, b};
    return x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
  endfunction

endpackage

### src/dbv_scan.sv
// Per-byte stream state: delimiter search, byte counts and both running hashes.
// Depends on dbv_pkg.
module dbv_scan (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  logic [7:0]    data_byte_i,
  input  logic          byte_valid_i,
  input  logic          last_i,
  output logic          fin_fire_o,
  output dbv_pkg::fin_t fin_o
);
  import dbv_pkg::*;

  typedef enum logic [1:0] {
    D_NONE   = 2'd0,
    D_CR     = 2'd1,
    D_CRLF   = 2'd2,
    D_CRLFCR = 2'd3
  } delim_e;

  delim_e            prog_q, prog_d;
  logic              found_q, found_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [CNT_W-1:0]  body_q, body_d;
  logic [HASH_W-1:0] whole_q, whole_d;
  logic [HASH_W-1:0] after_q, after_d;

  logic              room;
  logic              use_byte;
  delim_e            prog_nxt;
  logic              hit;

  assign room     = total_q < CNT_W'(BUFFER_BYTES);
  assign use_byte = byte_valid_i && room;

  // CR LF CR LF matcher.
  always_comb begin
    hit = 1'b0;
    if (data_byte_i == CHAR_CR) begin
      prog_nxt = (prog_q == D_CRLF) ? D_CRLFCR : D_CR;
    end else if (data_byte_i == CHAR_LF) begin
      unique case (prog_q)
        D_CR:     prog_nxt = D_CRLF;
        D_CRLFCR: begin
          prog_nxt = D_NONE;
          hit      = 1'b1;
        end
        default:  prog_nxt = D_NONE;
      endcase
    end else begin
      prog_nxt = D_NONE;
    end
  end

  always_comb begin
    prog_d  = prog_q;
    found_d = found_q;
    total_d = total_q;
    body_d  = body_q;
    whole_d = whole_q;
    after_d = after_q;
    if (use_byte) begin
      total_d = total_q + CNT_W'(1);
      whole_d = fnv_step(whole_q, data_byte_i);
      if (found_q) begin
        body_d  = body_q + CNT_W'(1);
        after_d = fnv_step(after_q, data_byte_i);
      end else begin
        prog_d  = prog_nxt;
        found_d = hit;
      end
    end
  end

  assign fin_fire_o = take_i && last_i;
  assign fin_o.len  = found_d ? body_d : total_d;
  assign fin_o.hash = found_d ? after_d : whole_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_q  <= D_NONE;
      found_q <= 1'b0;
      total_q <= '0;
      body_q  <= '0;
      whole_q <= FNV_BASIS;
      after_q <= FNV_BASIS;
    end else if (take_i) begin
      if (last_i) begin
        prog_q  <= D_NONE;
        found_q <= 1'b0;
        total_q <= '0;
        body_q  <= '0;
        whole_q <= FNV_BASIS;
        after_q <= FNV_BASIS;
      end else begin
        prog_q  <= prog_d;
        found_q <= found_d;
        total_q <= total_d;
        body_q  <= body_d;
        whole_q <= whole_d;
        after_q <= after_d;
      end
    end
  end

endmodule

### src/dbv_verdict.sv
// Result stages: holds a finished length and hash, grades it and drives the output.
// Depends on dbv_pkg.
module dbv_verdict (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fin_fire_i,
  input  dbv_pkg::fin_t             fin_i,
  input  logic [dbv_pkg::CFG_W-1:0] exp_size_i,
  input  logic [dbv_pkg::CFG_W-1:0] exp_sum_i,
  output logic                      busy_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic [dbv_pkg::LEN_W-1:0] body_length_o,
  output logic [dbv_pkg::HASH_W-1:0] body_hash_o
);
  import dbv_pkg::*;

  logic              fin_valid_q, fin_valid_d;
  fin_t              fin_q;
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic [LEN_W-1:0]  len_q;
  logic [HASH_W-1:0] hash_q;
  logic              move;

  assign move   = fin_valid_q && (!out_valid_q || !out_stall_i);
  assign busy_o = fin_valid_q && out_valid_q && out_stall_i;

  always_comb begin
    priority if (exp_size_i > CFG_W'(BUFFER_BYTES)) begin
      status_d = ST_TOO_BIG;
    end else if (CFG_W'(fin_q.len) != exp_size_i) begin
      status_d = ST_SIZE;
    end else if (fin_q.hash != exp_sum_i) begin
      status_d = ST_CHECKSUM;
    end else begin
      status_d = ST_OK;
    end
  end

  always_comb begin
    fin_valid_d = fin_valid_q;
    if (fin_fire_i) begin
      fin_valid_d = 1'b1;
    end else if (move) begin
      fin_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (move) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fin_valid_q <= fin_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire_i) begin
      fin_q <= fin_i;
    end
    if (move) begin
      status_q <= status_d;
      len_q    <= LEN_W'(fin_q.len);
      hash_q   <= fin_q.hash;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign body_length_o = len_q;
  assign body_hash_o   = hash_q;

endmodule

### src/download_body_verifier.sv
// Download body verifier: top level with the configuration registers.
// Depends on dbv_pkg, dbv_scan and dbv_verdict.
//
// The block takes an HTTP response one byte per request and, on the request
// marked last, returns the body length, the FNV-1a 32-bit hash of the body and
// a status (ok, too big, size mismatch, checksum mismatch). The body is what
// follows the first CR LF CR LF; without that delimiter the whole response is
// the body. Only the first 4096 bytes of a response count; later bytes are
// dropped without touching the hashes or the delimiter search. A request with
// byte_valid low carries no byte, which is how an empty response is closed.
// One input request is taken every clock cycle while input stall is low. The
// per-byte path is one FNV step (an XOR and a sum of six shifted copies of
// the hash) plus a count increment, all between the stream state registers.
// The edge that takes a result's last request captures length and hash in a
// holding stage; from there the result is graded into the output register,
// and is valid on the output, once the output is free. Those two stages
// buffer results, so input stall rises only when both hold a result and the
// output is stalled. There is no state to clear after reset.
// Expected size and checksum must be written through the configuration port
// only while no response is in flight, a rule on the user that the block does
// not enforce; status uses the values held when the output register loads.
module download_body_verifier (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [dbv_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       byte_valid_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [dbv_pkg::LEN_W-1:0]  body_length_o,
  output logic [dbv_pkg::HASH_W-1:0] body_hash_o
);
  import dbv_pkg::*;

  logic [CFG_W-1:0] exp_size_q;
  logic [CFG_W-1:0] exp_sum_q;
  logic             busy;
  logic             take;
  logic             fin_fire;
  fin_t             fin;

  // Configuration registers; both reset to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_size_q <= '0;
      exp_sum_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_EXP_SIZE: exp_size_q <= cfg_wdata_i;
        CFG_EXP_SUM:  exp_sum_q  <= cfg_wdata_i;
        default:      exp_sum_q  <= exp_sum_q;
      endcase
    end
  end

  // A request is taken whenever the result stages can absorb one more result.
  assign in_stall_o = busy;
  assign take       = in_valid_i && !busy;

  dbv_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .data_byte_i  (data_byte_i),
    .byte_valid_i (byte_valid_i),
    .last_i       (last_i),
    .fin_fire_o   (fin_fire),
    .fin_o        (fin)
  );

  dbv_verdict u_verdict (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fin_fire_i    (fin_fire),
    .fin_i         (fin),
    .exp_size_i    (exp_size_q),
    .exp_sum_i     (exp_sum_q),
    .busy_o        (busy),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .body_length_o (body_length_o),
    .body_hash_o   (body_hash_o)
  );

endmodule

### src/dbv_checker.sv
// Port-level checks for the download body verifier, bound to the top level.
// Depends on dbv_pkg and download_body_verifier_defines.svh.
`include "download_body_verifier_defines.svh"

module dbv_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       cfg_we_i,
  input logic                       cfg_index_i,
  input logic [dbv_pkg::CFG_W-1:0]  cfg_wdata_i,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [7:0]                 data_byte_i,
  input logic                       byte_valid_i,
  input logic                       last_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [1:0]                 status_o,
  input logic [dbv_pkg::LEN_W-1:0]  body_length_o,
  input logic [dbv_pkg::HASH_W-1:0] body_hash_o
);
  import dbv_pkg::*;

  // The input only backs up when a result is already waiting at the output.
  `DBV_ASSERT_SAME(a_stall_needs_result, !out_valid_o, !in_stall_o)

  // A stalled result stays put.
  `DBV_ASSERT_NEXT(a_result_held, out_valid_o && out_stall_i,
                   out_valid_o && $stable(status_o) && $stable(body_length_o) &&
                   $stable(body_hash_o))

  // A reported body never exceeds the buffer.
  `DBV_ASSERT_SAME(a_len_in_range, out_valid_o,
                   {{(CFG_W-LEN_W){1'b0}}, body_length_o} <= CFG_W'(BUFFER_BYTES))

endmodule

bind download_body_verifier dbv_checker u_dbv_checker (.*);
